// ===== hw/rtl/chft_pkg.sv =====
// ----------------------------------------------------------------------------
// chft_pkg
// Shared types and constants for the counting fingerprint hint table.
// ----------------------------------------------------------------------------
package chft_pkg;

  localparam int WAYS      = 4;
  localparam int SET_COUNT = 256;
  localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int HASH_W    = 64;
  localparam int FP_W      = 32;
  localparam int CNT_W     = 8;
  localparam int GEN_W     = 24;
  localparam int GCNT_W    = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [GCNT_W-1:0] GEN_INIT = GCNT_W'(1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PROBE  = 2'd2,
    OP_CLEAR  = 2'd3
  } chft_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } chft_state_t;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [CNT_W-1:0] count;
    logic [FP_W-1:0]  fp;
  } chft_way_t;

  typedef chft_way_t [WAYS-1:0] chft_row_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch request, read set row
    logic clear;   // wipe table, reset generation
    logic commit;  // write back row / emit probe result
  } chft_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic probe;     // pending request is a probe
    logic out_full;  // result register held by receiver
  } chft_sts_t;

endpackage

// ===== hw/rtl/chft_if.sv =====
// ----------------------------------------------------------------------------
// chft_in_if / chft_out_if
// Valid/ready channels for requests and probe results.
// ----------------------------------------------------------------------------
interface chft_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [chft_pkg::HASH_W-1:0]  key_hash;

  modport source (output valid, output operation, output key_hash, input ready);
  modport sink   (input valid, input operation, input key_hash, output ready);
endinterface

interface chft_out_if;
  logic                        valid;
  logic                        ready;
  logic [chft_pkg::CNT_W-1:0]  hint_count;

  modport source (output valid, output hint_count, input ready);
  modport sink   (input valid, input hint_count, output ready);
endinterface

// ===== hw/rtl/chft_ctrl.sv =====
// ----------------------------------------------------------------------------
// chft_ctrl
// Request sequencer: accept, then execute for each add, remove or probe request.
// ----------------------------------------------------------------------------
module chft_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_operation,
  output logic                in_ready,
  input  chft_pkg::chft_sts_t sts,
  output chft_pkg::chft_cmd_t cmd
);

  chft_pkg::chft_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      chft_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (chft_pkg::chft_op_t'(in_operation) == chft_pkg::OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = chft_pkg::ST_EXEC;
          end
        end
      end
      chft_pkg::ST_EXEC: begin
        if (!(sts.probe && sts.out_full)) begin
          cmd.commit = 1'b1;
          state_nxt  = chft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = chft_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/chft_datapath.sv =====
// ----------------------------------------------------------------------------
// chft_datapath
// Set row memory, row valid bits, generation counter, way match/update
// logic and the probe result register.
// ----------------------------------------------------------------------------
module chft_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chft_pkg::chft_cmd_t           cmd,
  output chft_pkg::chft_sts_t           sts,
  input  logic [1:0]                    in_operation,
  input  logic [chft_pkg::HASH_W-1:0]   in_key_hash,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [chft_pkg::CNT_W-1:0]    out_hint_count
);

  chft_pkg::chft_row_t mem [chft_pkg::SET_COUNT];

  chft_pkg::chft_op_t                 op_r;
  logic [chft_pkg::FP_W-1:0]          fp_r;
  logic [chft_pkg::SET_W-1:0]         set_r;
  chft_pkg::chft_row_t                row_rd_r;
  logic                               row_ok_r;
  logic [chft_pkg::SET_COUNT-1:0]     valid_r;
  logic [chft_pkg::GCNT_W-1:0]        gen_cnt_r, gen_cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [chft_pkg::CNT_W-1:0]         out_count_r;

  logic [chft_pkg::SET_W-1:0]         set_in;
  logic [chft_pkg::FP_W-1:0]          fp_in;

  chft_pkg::chft_row_t                row;
  chft_pkg::chft_row_t                row_new;
  logic                               wr;
  logic                               wr_en;
  logic [chft_pkg::CNT_W-1:0]         best;

  assign set_in = in_key_hash[chft_pkg::FP_W +: chft_pkg::SET_W];
  assign fp_in  = in_key_hash[chft_pkg::FP_W-1:0] ^
                  in_key_hash[chft_pkg::HASH_W-1:chft_pkg::FP_W];

  // request latch and registered row read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= chft_pkg::chft_op_t'(in_operation);
      fp_r     <= fp_in;
      set_r    <= set_in;
      row_rd_r <= mem[set_in];
      row_ok_r <= valid_r[set_in];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[set_r] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[set_r] <= 1'b1;
    end
  end

  always_comb begin
    logic [chft_pkg::WAYS-1:0]  live;
    logic [chft_pkg::WAYS-1:0]  hit;
    logic                       hit_any;
    logic [chft_pkg::WAY_W-1:0] hit_idx;
    logic                       empty_any;
    logic [chft_pkg::WAY_W-1:0] empty_idx;
    logic [chft_pkg::WAY_W-1:0] victim;
    logic [chft_pkg::GEN_W:0]   oldest;
    logic [chft_pkg::WAY_W-1:0] tgt;
    logic [chft_pkg::CNT_W-1:0] cnt;

    row       = row_ok_r ? row_rd_r : '0;
    hit_any   = 1'b0;
    hit_idx   = '0;
    empty_any = 1'b0;
    empty_idx = '0;
    victim    = '0;
    oldest    = '1;
    best      = '0;
    for (int i = 0; i < chft_pkg::WAYS; i++) begin
      live[i] = (row[i].count != '0);
      hit[i]  = live[i] && (row[i].fp == fp_r);
    end
    for (int i = chft_pkg::WAYS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = chft_pkg::WAY_W'(i);
      end
      if (!live[i]) begin
        empty_any = 1'b1;
        empty_idx = chft_pkg::WAY_W'(i);
      end
    end
    for (int i = 0; i < chft_pkg::WAYS; i++) begin
      if (live[i] && ({1'b0, row[i].gen} < oldest)) begin
        oldest = {1'b0, row[i].gen};
        victim = chft_pkg::WAY_W'(i);
      end
      if (hit[i] && (row[i].count > best)) begin
        best = row[i].count;
      end
    end

    row_new = row;
    wr      = 1'b0;
    tgt     = '0;
    cnt     = '0;
    case (op_r)
      chft_pkg::OP_ADD: begin
        wr = 1'b1;
        if (hit_any) begin
          tgt = hit_idx;
          cnt = (row[hit_idx].count == chft_pkg::CNT_MAX) ? chft_pkg::CNT_MAX
                : row[hit_idx].count + chft_pkg::CNT_W'(1);
        end else begin
          tgt = empty_any ? empty_idx : victim;
          cnt = chft_pkg::CNT_W'(1);
        end
      end
      chft_pkg::OP_REMOVE: begin
        wr  = hit_any;
        tgt = hit_idx;
        cnt = row[hit_idx].count - chft_pkg::CNT_W'(1);
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    if (wr) begin
      row_new[tgt] = '{gen: gen_cnt_r[chft_pkg::GEN_W-1:0], count: cnt, fp: fp_r};
    end
  end

  assign wr_en = cmd.commit && wr;

  always_comb begin
    gen_cnt_nxt = gen_cnt_r;
    if (cmd.clear) begin
      gen_cnt_nxt = chft_pkg::GEN_INIT;
    end else if (wr_en) begin
      gen_cnt_nxt = gen_cnt_r + chft_pkg::GCNT_W'(1);
      if (gen_cnt_nxt == '0) begin
        gen_cnt_nxt = chft_pkg::GEN_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_cnt_r <= chft_pkg::GEN_INIT;
    end else begin
      gen_cnt_r <= gen_cnt_nxt;
    end
  end

  // probe result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.commit && (op_r == chft_pkg::OP_PROBE)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (op_r == chft_pkg::OP_PROBE)) begin
      out_count_r <= best;
    end
  end

  assign sts.probe      = (op_r == chft_pkg::OP_PROBE);
  assign sts.out_full   = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_hint_count = out_count_r;

endmodule

// ===== hw/rtl/counting_fingerprint_hint_table.sv =====
// ----------------------------------------------------------------------------
// counting_fingerprint_hint_table
// Set-associative counting fingerprint table with add/remove/probe/clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : request channel (operation, key_hash), valid/ready.
//   out_if : probe result channel (hint_count), valid/ready.
//   Only probe requests produce a result; add, remove and clear produce none.
//   Add, remove and probe each have an accept step and an execute step: the
//   accept step issues the registered read of the set row, the execute step
//   compares all ways, then writes the row back (add; remove on a hit) or
//   loads the result register (probe). Clear is done in its accept cycle:
//   row valid bits drop and the generation counter returns to 1; the next
//   request is taken in the following cycle.
//   The result sits in an output register; new requests are taken while it
//   waits. A probe finding that register still held waits in execute until
//   the receiver takes the old result.
//   Reset (rst_n low, synchronous) empties every set at once through the row
//   valid bits and sets the generation counter to 1; no clearing pass.
// ----------------------------------------------------------------------------
module counting_fingerprint_hint_table (
  input  logic        clk,
  input  logic        rst_n,
  chft_in_if.sink     in_if,
  chft_out_if.source  out_if
);

  chft_pkg::chft_cmd_t cmd;
  chft_pkg::chft_sts_t sts;

  chft_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_operation (in_if.operation),
    .in_ready     (in_if.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  chft_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_if.operation),
    .in_key_hash    (in_if.key_hash),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_hint_count (out_if.hint_count)
  );

endmodule

// ===== hw/rtl/chft_checker.sv =====
// ----------------------------------------------------------------------------
// chft_checker
// Port-level timing checks for the counting fingerprint hint table.
// ----------------------------------------------------------------------------
module chft_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [1:0]                 in_operation,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [chft_pkg::CNT_W-1:0] out_hint_count
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hint_count))
    else $error("result dropped or changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation != chft_pkg::OP_CLEAR) |=> !in_ready)
    else $error("request taken during execute cycle");

  a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == chft_pkg::OP_CLEAR) |=> in_ready)
    else $error("clear did not finish in one cycle");

  a_probe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == chft_pkg::OP_PROBE) && !out_valid |-> ##2 out_valid)
    else $error("probe result late");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation != chft_pkg::OP_PROBE) && !out_valid
      |=> !out_valid ##1 !out_valid)
    else $error("result from non-probe request");

endmodule

bind counting_fingerprint_hint_table chft_checker u_chft_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_operation   (in_if.operation),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_hint_count (out_if.hint_count)
);
